// ===== rtl/bnms_pkg.sv =====
`timescale 1ns / 1ps

package bnms_pkg;

  // Largest run of boxes held on chip.
  localparam int unsigned MaxBoxesDef = 64;

  // Register widths.
  localparam int unsigned ThrW  = 16;
  localparam int unsigned TopKW = 7;

  // Cycles from a settled operand pair to a valid overlap decision.
  localparam int unsigned IouLat = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IOU_THRESHOLD  = 2'd0,
    CFG_TOP_K          = 2'd1,
    CFG_GROUP_BY_IMAGE = 2'd2
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_PUSH,
    ST_SUPP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [15:0] x_low;
    logic [15:0] y_low;
    logic [15:0] x_high;
    logic [15:0] y_high;
    logic [15:0] score;
    logic [7:0]  category;
    logic [15:0] frame_id;
    logic        last_box;
  } box_in_t;

  typedef struct packed {
    logic [15:0] kept_x_low;
    logic [15:0] kept_y_low;
    logic [15:0] kept_x_high;
    logic [15:0] kept_y_high;
    logic [15:0] kept_score;
    logic [7:0]  kept_class;
    logic [15:0] kept_image;
    logic        last_kept;
  } box_out_t;

  // One stored box.
  typedef struct packed {
    logic [15:0] x_low;
    logic [15:0] y_low;
    logic [15:0] x_high;
    logic [15:0] y_high;
    logic [15:0] score;
    logic [7:0]  category;
    logic [15:0] frame_id;
  } box_t;

endpackage

// ===== rtl/box_non_maximum_suppression_top.sv =====
`timescale 1ns / 1ps

// Greedy per-group non-maximum suppression over a run of up to MAX_BOXES boxes.
// Boxes load one word per cycle into a ring of cells; a word with last_box set
// closes the run, and a box arriving while the ring is full is dropped. Each
// kept box then costs one search rotation of the ring, a push step that hands
// it to the output side, and, unless top_k is reached, one suppression
// rotation, where every other alive box of the same group holds the ring
// while the pipelined overlap unit at the ring head settles. A run ends with a
// flush, after one last search rotation that finds no box or once top_k is
// reached. No new box is accepted until the run has been handed to the output
// side. Kept boxes leave in ascending group key, descending score, and the
// final one carries last_kept. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module box_non_maximum_suppression_top import bnms_pkg::*; #(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  box_in_t          in_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output box_out_t         out_data_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  // Configuration registers.
  logic [ThrW-1:0]  thr_q;
  logic [TopKW-1:0] topk_q;
  logic             by_img_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrW'(32768);
      topk_q   <= '0;
      by_img_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IOU_THRESHOLD:  thr_q    <= cfg_data_i[ThrW-1:0];
        CFG_TOP_K:          topk_q   <= cfg_data_i[TopKW-1:0];
        CFG_GROUP_BY_IMAGE: by_img_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Ring of cells; cell 0 is the head seen by the compare logic.
  box_t            c_box   [MAX_BOXES];
  logic [IdxW-1:0] c_idx   [MAX_BOXES];
  logic            c_alive [MAX_BOXES];

  logic            shift, clr, kill;
  box_t            tail_box;
  logic [IdxW-1:0] tail_idx;
  logic            tail_alive;

  state_e state_q, state_d;
  logic   in_acc, load;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;

  logic [CntW-1:0] cnt_q, cnt_d;
  assign load = in_acc && (cnt_q < CntW'(MAX_BOXES));

  genvar g;
  generate
    for (g = 0; g < MAX_BOXES; g++) begin : g_cell
      if (g == MAX_BOXES - 1) begin : g_tail
        bnms_cell #(.IdxW(IdxW)) u_cell (
          .clk_i, .rst_ni, .shift_i(shift), .clr_i(clr),
          .nxt_box_i(tail_box), .nxt_idx_i(tail_idx), .nxt_alive_i(tail_alive),
          .box_o(c_box[g]), .idx_o(c_idx[g]), .alive_o(c_alive[g])
        );
      end else begin : g_body
        bnms_cell #(.IdxW(IdxW)) u_cell (
          .clk_i, .rst_ni, .shift_i(shift), .clr_i(clr),
          .nxt_box_i(c_box[g+1]), .nxt_idx_i(c_idx[g+1]), .nxt_alive_i(c_alive[g+1]),
          .box_o(c_box[g]), .idx_o(c_idx[g]), .alive_o(c_alive[g])
        );
      end
    end
  endgenerate

  // The tail takes a new box while loading, otherwise the rotated head word.
  always_comb begin
    if (load) begin
      tail_box.x_low    = in_data_i.x_low;
      tail_box.y_low    = in_data_i.y_low;
      tail_box.x_high   = in_data_i.x_high;
      tail_box.y_high   = in_data_i.y_high;
      tail_box.score    = in_data_i.score;
      tail_box.category = in_data_i.category;
      tail_box.frame_id = in_data_i.frame_id;
      tail_idx          = cnt_q[IdxW-1:0];
      tail_alive        = 1'b1;
    end else begin
      tail_box   = c_box[0];
      tail_idx   = c_idx[0];
      tail_alive = c_alive[0] && !kill;
    end
  end

  // Best box of the current search, also the box being suppressed against.
  box_t            best_q, best_d;
  logic [IdxW-1:0] bidx_q, bidx_d;
  logic            found_q, found_d;
  box_t            pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [2:0]      sub_q, sub_d;
  logic [TopKW-1:0] kept_q, kept_d;

  logic [15:0] head_key, best_key;
  logic        better, hit;

  assign head_key = by_img_q ? c_box[0].frame_id : {8'h00, c_box[0].category};
  assign best_key = by_img_q ? best_q.frame_id   : {8'h00, best_q.category};

  // Ordering: lower key, then higher score, then earlier arrival.
  always_comb begin
    better = c_alive[0] && (!found_q || (head_key < best_key) ||
             ((head_key == best_key) && (c_box[0].score > best_q.score)) ||
             ((head_key == best_key) && (c_box[0].score == best_q.score) &&
              (c_idx[0] < bidx_q)));
  end

  bnms_iou u_iou (
    .clk_i, .a_i(best_q), .b_i(c_box[0]), .thr_i(thr_q), .hit_o(hit)
  );

  // Output register.
  box_out_t out_q, out_d;
  logic     out_v_q, out_v_d;
  logic     out_free, out_wr;
  logic     out_last;

  assign out_free = !out_v_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    best_d   = best_q;
    bidx_d   = bidx_q;
    found_d  = found_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    pos_d    = pos_q;
    sub_d    = sub_q;
    kept_d   = kept_q;
    shift    = load;
    clr      = 1'b0;
    kill     = 1'b0;
    out_wr   = 1'b0;
    out_last = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (load) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (in_acc && in_data_i.last_box) begin
          state_d = ST_SEARCH;
          found_d = 1'b0;
          pos_d   = '0;
        end
      end

      ST_SEARCH: begin
        shift = 1'b1;
        if (better) begin
          best_d  = c_box[0];
          bidx_d  = c_idx[0];
          found_d = 1'b1;
        end
        pos_d = pos_q + IdxW'(1);
        if (pos_q == IdxW'(MAX_BOXES - 1)) begin
          pos_d = '0;
          if (found_q || better) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_PUSH: begin
        if (!pend_v_q || out_free) begin
          out_wr   = pend_v_q;
          pend_d   = best_q;
          pend_v_d = 1'b1;
          kept_d   = kept_q + TopKW'(1);
          sub_d    = '0;
          if ((topk_q != '0) && (kept_q + TopKW'(1) == topk_q)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_SUPP;
          end
        end
      end

      ST_SUPP: begin
        if (!c_alive[0] || (head_key != best_key)) begin
          shift = 1'b1;
        end else if (c_idx[0] == bidx_q) begin
          shift = 1'b1;
          kill  = 1'b1;
        end else if (sub_q < 3'(IouLat)) begin
          sub_d = sub_q + 3'd1;
        end else begin
          shift = 1'b1;
          kill  = hit;
        end
        if (shift) begin
          sub_d = '0;
          pos_d = pos_q + IdxW'(1);
          if (pos_q == IdxW'(MAX_BOXES - 1)) begin
            pos_d   = '0;
            found_d = 1'b0;
            state_d = ST_SEARCH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          out_wr   = pend_v_q;
          out_last = 1'b1;
          pend_v_d = 1'b0;
          clr      = 1'b1;
          cnt_d    = '0;
          kept_d   = '0;
          state_d  = ST_LOAD;
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    if (out_wr) begin
      out_d.kept_x_low  = pend_q.x_low;
      out_d.kept_y_low  = pend_q.y_low;
      out_d.kept_x_high = pend_q.x_high;
      out_d.kept_y_high = pend_q.y_high;
      out_d.kept_score  = pend_q.score;
      out_d.kept_class  = pend_q.category;
      out_d.kept_image  = pend_q.frame_id;
      out_d.last_kept   = out_last;
      out_v_d           = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      pos_q    <= '0;
      sub_q    <= '0;
      kept_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      pos_q    <= pos_d;
      sub_q    <= sub_d;
      kept_q   <= kept_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bidx_q <= bidx_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_v_q;

  // The box count never passes the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_BOXES))
    else $error("box count above ring size");

  // The overlap wait never runs past the unit latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q <= 3'(IouLat))
    else $error("overlap wait overran");

  // Kept boxes never exceed the configured limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (topk_q != '0) |-> (kept_q <= topk_q))
    else $error("kept count above top_k");

  // A flush always empties the pending slot and returns to loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && state_d == ST_LOAD) |=> !pend_v_q && cnt_q == '0)
    else $error("flush left state behind");

endmodule

// ===== rtl/bnms_cell.sv =====
`timescale 1ns / 1ps

module bnms_cell import bnms_pkg::*; #(
  parameter int unsigned IdxW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            clr_i,
  input  box_t            nxt_box_i,
  input  logic [IdxW-1:0] nxt_idx_i,
  input  logic            nxt_alive_i,
  output box_t            box_o,
  output logic [IdxW-1:0] idx_o,
  output logic            alive_o
);

  box_t            box_q;
  logic [IdxW-1:0] idx_q;
  logic            alive_q, alive_d;

  // Payload takes the neighbor's word on a shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      box_q <= nxt_box_i;
      idx_q <= nxt_idx_i;
    end
  end

  // The alive mark moves with the payload and is cleared at the end of a run.
  always_comb begin
    alive_d = alive_q;
    if (clr_i) begin
      alive_d = 1'b0;
    end else if (shift_i) begin
      alive_d = nxt_alive_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else begin
      alive_q <= alive_d;
    end
  end

  assign box_o   = box_q;
  assign idx_o   = idx_q;
  assign alive_o = alive_q;

endmodule

// ===== rtl/bnms_iou.sv =====
`timescale 1ns / 1ps

module bnms_iou import bnms_pkg::*; (
  input  logic            clk_i,
  input  box_t            a_i,
  input  box_t            b_i,
  input  logic [ThrW-1:0] thr_i,
  output logic            hit_o
);

  // Stage 1: intersection edges and box sides.
  logic        disj1_q;
  logic [15:0] ow_q, oh_q, aw_q, ah_q, bw_q, bh_q;
  // Stage 2: areas.
  logic        disj2_q;
  logic [31:0] ov2_q, aa_q, ab_q;
  // Stage 3: union.
  logic        disj3_q;
  logic [31:0] ov3_q;
  logic [32:0] uni_q;
  // Stage 4: scaled terms.
  logic        disj4_q;
  logic [47:0] ovs_q;
  logic [48:0] prod_q;

  logic [15:0] oxl, oxh, oyl, oyh;

  always_comb begin
    oxl = (a_i.x_low  > b_i.x_low)  ? a_i.x_low  : b_i.x_low;
    oxh = (a_i.x_high < b_i.x_high) ? a_i.x_high : b_i.x_high;
    oyl = (a_i.y_low  > b_i.y_low)  ? a_i.y_low  : b_i.y_low;
    oyh = (a_i.y_high < b_i.y_high) ? a_i.y_high : b_i.y_high;
  end

  always_ff @(posedge clk_i) begin
    disj1_q <= (oxl > oxh) || (oyl > oyh);
    ow_q    <= oxh - oxl;
    oh_q    <= oyh - oyl;
    aw_q    <= a_i.x_high - a_i.x_low;
    ah_q    <= a_i.y_high - a_i.y_low;
    bw_q    <= b_i.x_high - b_i.x_low;
    bh_q    <= b_i.y_high - b_i.y_low;

    disj2_q <= disj1_q;
    ov2_q   <= ow_q * oh_q;
    aa_q    <= aw_q * ah_q;
    ab_q    <= bw_q * bh_q;

    disj3_q <= disj2_q;
    ov3_q   <= ov2_q;
    uni_q   <= {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, ov2_q};

    disj4_q <= disj3_q;
    ovs_q   <= {ov3_q, 16'h0000};
    prod_q  <= thr_i * uni_q;
  end

  // Suppress when overlap * 65536 exceeds threshold * union.
  assign hit_o = !disj4_q && ({1'b0, ovs_q} > prod_q);

endmodule
